@@ hw/rtl/spherical_bessel_basis_eval_macros.svh @@
// assertion helpers for the bessel basis block
`ifndef SPHERICAL_BESSEL_BASIS_EVAL_MACROS_SVH
`define SPHERICAL_BESSEL_BASIS_EVAL_MACROS_SVH

// implication checked on every edge outside reset
`define SBB_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("sbb check failed");

// implication whose rhs is checked in the cycle after the lhs
`define SBB_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("sbb check failed");

`endif

@@ hw/rtl/sbb_pkg.sv @@
package sbb_pkg;
  localparam int MaxFuncs = 64;
  localparam int CntW = 7;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic [30:0] SatMax = 31'h7FFF_FFFF;

  // reciprocals rounded up, exact floor for any 32 bit dividend
  localparam logic [32:0] Recip110 = 33'(((72'd1 << 39) + 72'd109) / 72'd110);
  localparam logic [32:0] Recip72 = 33'(((72'd1 << 39) + 72'd71) / 72'd72);
  localparam logic [32:0] Recip42 = 33'(((72'd1 << 38) + 72'd41) / 72'd42);
  localparam logic [32:0] Recip20 = 33'(((72'd1 << 37) + 72'd19) / 72'd20);
  localparam logic [32:0] Recip6 = 33'(((72'd1 << 35) + 72'd5) / 72'd6);

  localparam logic [1:0] RegCutoff = 2'd0;
  localparam logic [1:0] RegInvCut = 2'd1;
  localparam logic [1:0] RegAmp = 2'd2;
  localparam logic [1:0] RegCount = 2'd3;

  typedef struct packed {
    logic [23:0] radius;
    logic [7:0]  slot_base;
    logic        beyond;
    logic        zero;
    logic [6:0]  count;
  } sbb_job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_PHASE, S_FOLD, S_ANG, S_SQ, S_POLY, S_SIN, S_MAG, S_OUT
  } sbb_state_t;
endpackage

@@ hw/rtl/sbb_stream_if.sv @@
interface sbb_stream_if #(parameter int W = 8) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/sbb_front.sv @@
module sbb_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [23:0] radius,
  input  logic [7:0] slot_base,
  input  logic [23:0] cutoff_radius,
  input  logic [6:0] function_count,
  output logic q_valid,
  input  logic q_ready,
  output sbb_pkg::sbb_job_t q_job
);
  import sbb_pkg::*;
  // two entry queue toward the back part
  sbb_job_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  sbb_job_t job;
  logic push, pop;

  always_comb begin
    job.radius = radius;
    job.slot_base = slot_base;
    job.beyond = radius > cutoff_radius;
    job.zero = radius == 24'd0;
    job.count = (function_count > CntW'(MaxFuncs)) ? CntW'(MaxFuncs) : function_count;
  end

  assign in_ready = fill != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = fill != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_job = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hw/rtl/sbb_back.sv @@
module sbb_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  sbb_pkg::sbb_job_t q_job,
  input  logic [23:0] inverse_cutoff,
  input  logic [23:0] amplitude_scale,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] basis_value,
  output logic [8:0] slot,
  output logic last_value
);
  import sbb_pkg::*;
  `include "spherical_bessel_basis_eval_macros.svh"

  sbb_state_t state, state_next;
  sbb_job_t job;
  logic [6:0] k;
  logic [2:0] step;
  logic half;
  logic [63:0] t;          // phase, and zero radius product
  logic [31:0] a, s, p, sn;
  logic [31:0] pdiv;       // registered dividend of one polynomial step
  logic [55:0] num;        // magnitude before saturation
  logic [36:0] dvd;        // dividend, quotient bits shift in from the bottom
  logic [23:0] rem;
  logic [24:0] trial;
  logic [5:0] dcnt;
  logic neg;
  logic [63:0] mul;
  logic [32:0] recip;
  logic [5:0] rshift;
  logic [71:0] rprod;
  logic [31:0] div_q;
  logic [31:0] sat;

  // polynomial divisors, one per step, by reciprocal multiply
  always_comb begin
    case (step)
      3'd0: begin
        recip = Recip110;
        rshift = 6'd39;
      end
      3'd1: begin
        recip = Recip72;
        rshift = 6'd39;
      end
      3'd2: begin
        recip = Recip42;
        rshift = 6'd38;
      end
      3'd3: begin
        recip = Recip20;
        rshift = 6'd37;
      end
      default: begin
        recip = Recip6;
        rshift = 6'd35;
      end
    endcase
    rprod = 72'(pdiv) * 72'(recip);
    div_q = 32'(rprod >> rshift);
  end
  assign mul = 64'(s) * 64'(p);

  assign trial = {rem, dvd[36]};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_PHASE;
      S_PHASE: state_next = job.beyond ? S_MAG : S_FOLD;
      S_FOLD: state_next = job.zero ? S_MAG : S_ANG;
      S_ANG: state_next = S_SQ;
      S_SQ: state_next = S_POLY;
      S_POLY: if (step == 3'd4 && half) state_next = S_SIN;
      S_SIN: state_next = S_DIV;
      S_DIV: if (dcnt == 6'd37) state_next = S_MAG;
      S_MAG: state_next = S_OUT;
      S_OUT: if (!out_valid || out_ready) begin
        if (k == job.count) state_next = S_IDLE;
        else state_next = S_PHASE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign q_ready = state == S_IDLE;

  always_comb begin
    if (num[55:31] != 25'd0) sat = {1'b0, SatMax};
    else sat = {1'b0, num[30:0]};
    if (job.beyond) sat = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state == S_OUT) || (out_valid && !out_ready);
    end
    case (state)
      S_IDLE: begin
        job <= q_job;
        k <= 7'd1;
      end
      S_PHASE: begin
        if (job.zero) t <= 64'(k) * 64'(inverse_cutoff);
        else t <= 64'(job.radius) * 64'(inverse_cutoff);
      end
      S_FOLD: begin
        // zero radius: scale by pi; otherwise scale by order
        if (job.zero) t <= (64'(t[29:0]) * 64'(PiQ30)) >> 30;
        else t <= 64'(t[47:0] * 48'(k));
      end
      S_ANG: begin
        // fold to half period
        neg <= t[40];
        if (t[39:0] > 40'h80_0000_0000) a <= 32'((41'h100_0000_0000 - 41'(t[39:0])) >> 10);
        else a <= 32'(t[39:10]);
        step <= 3'd7;
        half <= 1'b0;
      end
      S_SQ: begin
        a <= 32'((64'(a) * 64'(PiQ30)) >> 30);
      end
      S_POLY: begin
        if (step == 3'd7) begin
          s <= 32'((64'(a) * 64'(a)) >> 30);
          step <= 3'd0;
          half <= 1'b0;
        end else if (!half) begin
          pdiv <= (step == 3'd0) ? s : mul[61:30];
          half <= 1'b1;
        end else begin
          p <= 32'(OneQ30) - div_q;
          step <= step + 3'd1;
          half <= 1'b0;
        end
      end
      S_SIN: begin
        sn <= 32'((64'(a) * 64'(p)) >> 30);
        dcnt <= 6'd0;
      end
      S_DIV: begin
        // restoring divide by the radius, one quotient bit per cycle
        if (dcnt == 6'd0) begin
          dvd <= 37'((64'(amplitude_scale) * 64'(sn)) >> 18);
          rem <= 24'd0;
        end else if (trial >= {1'b0, job.radius}) begin
          rem <= 24'(trial - {1'b0, job.radius});
          dvd <= {dvd[35:0], 1'b1};
        end else begin
          rem <= trial[23:0];
          dvd <= {dvd[35:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
      S_MAG: begin
        if (job.beyond) begin
          neg <= 1'b0;
        end else if (job.zero) begin
          num <= 56'((64'(t[31:0]) * 64'(amplitude_scale)) >> 28);
          neg <= 1'b0;
        end else begin
          num <= 56'(dvd);
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          basis_value <= neg ? (32'd0 - sat) : sat;
          slot <= 9'(job.slot_base) + 9'(k) - 9'd1;
          last_value <= k == job.count;
          k <= k + 7'd1;
        end
      end
      default: ;
    endcase
  end

  `SBB_ASSERT_IMP(a_ready_idle, q_ready, state == S_IDLE)
  `SBB_ASSERT_IMP(a_k_range, state == S_OUT, k <= 7'(MaxFuncs))
  `SBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

@@ hw/rtl/spherical_bessel_basis_eval.sv @@
// channel | dir | payload
// in      | in  | radius[23:0], slot_base[7:0]
// out     | out | basis_value[31:0], slot[8:0], last_value
// cfg     | in  | cfg_we, cfg_index[1:0], cfg_data[23:0]
// nonzero radius within cutoff: each result runs the polynomial steps and the divider
// zero radius and beyond cutoff skip both; each radius also passes through the idle state
// results for one radius come in order, k = 1 .. function_count, capped at 64
// rst is synchronous and restores register defaults
// out stalls hold the back part; the front queue keeps taking up to two radii
module spherical_bessel_basis_eval (
  input  logic clk,
  input  logic rst,
  sbb_stream_if.sink in_ch,
  sbb_stream_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import sbb_pkg::*;
  logic [23:0] cutoff_radius, inverse_cutoff, amplitude_scale;
  logic [6:0] function_count;
  logic q_valid, q_ready;
  sbb_job_t q_job;
  logic [31:0] bv;
  logic [8:0] sl;
  logic lv;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_radius <= 24'd327680;
      inverse_cutoff <= 24'd13107;
      amplitude_scale <= 24'd10486;
      function_count <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCutoff: cutoff_radius <= cfg_data;
        RegInvCut: inverse_cutoff <= cfg_data;
        RegAmp: amplitude_scale <= cfg_data;
        RegCount: function_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  sbb_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid && function_count != 7'd0), .in_ready(in_ch.ready),
    .radius(in_ch.data[31:8]), .slot_base(in_ch.data[7:0]),
    .cutoff_radius, .function_count,
    .q_valid, .q_ready, .q_job
  );

  sbb_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job,
    .inverse_cutoff, .amplitude_scale,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .basis_value(bv), .slot(sl), .last_value(lv)
  );

  assign out_ch.data = {bv, sl, lv};
endmodule

@@ dv/spherical_bessel_basis_eval_checker.sv @@
`timescale 1ns / 1ps

module spherical_bessel_basis_eval_checker
  import sbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sbb_stream_if       in_ch,
  sbb_stream_if       out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  slot;
    logic        last;
  } basis_result_t;

  logic [63:0] cutoff_q, inv_cut_q, amp_q;
  logic [6:0]  count_q;
  basis_result_t basis_q[$];

  // sine of pi*z, z in [0, 0.5] as q0.30, truncating polynomial
  function automatic logic [63:0] half_turn_sine(logic [63:0] z);
    logic [63:0] a, s, p, one;
    one = 64'(OneQ30);
    a = (z * 64'(PiQ30)) >> 30;
    s = (a * a) >> 30;
    p = one - s / 110;
    p = one - ((s * p) >> 30) / 72;
    p = one - ((s * p) >> 30) / 42;
    p = one - ((s * p) >> 30) / 20;
    p = one - ((s * p) >> 30) / 6;
    return (a * p) >> 30;
  endfunction

  function automatic logic [31:0] clip_signed(logic [63:0] mag, bit neg);
    logic [63:0] m;
    m = (mag > 64'(SatMax)) ? 64'(SatMax) : mag;
    return neg ? 32'(64'd0 - m) : m[31:0];
  endfunction

  function automatic logic [31:0] basis_term(logic [63:0] r, logic [63:0] k);
    logic [63:0] w, t, u;
    bit neg;
    if (r > cutoff_q) return 32'd0;
    if (r == 0) begin
      w = ((k * inv_cut_q) * 64'(PiQ30)) >> 30;
      return clip_signed((w * amp_q) >> 28, 1'b0);
    end
    t = r * inv_cut_q * k;
    neg = t[40];
    u = {24'd0, t[39:0]};
    if (u > (64'd1 << 39)) u = (64'd1 << 40) - u;
    return clip_signed((amp_q * half_turn_sine(u >> 10)) / (r << 18), neg);
  endfunction

  always @(posedge clk) begin
    basis_result_t got, want;
    int n;
    if (rst) begin
      cutoff_q = 64'd327680;
      inv_cut_q = 64'd13107;
      amp_q = 64'd10486;
      count_q = 7'd1;
      basis_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegCutoff: cutoff_q = 64'(cfg_data);
          RegInvCut: inv_cut_q = 64'(cfg_data);
          RegAmp:    amp_q = 64'(cfg_data);
          RegCount:  count_q = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%0d/%0d",
                   $time, got.value, got.slot, got.last);
          errors++;
        end else begin
          want = basis_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d",
                     $time, want.value, want.slot, want.last,
                     got.value, got.slot, got.last);
            errors++;
          end
        end
      end
      // one expectation per basis order
      if (in_ch.valid && in_ch.ready) begin
        n = (count_q > MaxFuncs) ? MaxFuncs : int'(count_q);
        for (int k = 1; k <= n; k++) begin
          want.value = basis_term(64'(in_ch.data[31:8]), 64'(k));
          want.slot = 9'(in_ch.data[7:0]) + 9'(k - 1);
          want.last = (k == n);
          basis_q.push_back(want);
        end
      end
    end
    pending = basis_q.size();
  end

endmodule

@@ dv/spherical_bessel_basis_eval_tb.sv @@
`timescale 1ns / 1ps

module spherical_bessel_basis_eval_tb;
  import sbb_pkg::*;

  localparam int CycleLimit = 12000000;
  localparam int DrainCycles = 300;   // settling time after the last result
  localparam int RandomItems = 440;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;
  int errors, pending, cycles;
  int burst_left, sent;
  logic [23:0] cur_cutoff;

  sbb_stream_if #(.W(32)) in_if (clk);
  sbb_stream_if #(.W(42)) out_if (clk);

  always #5 clk = ~clk;

  spherical_bessel_basis_eval i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  spherical_bessel_basis_eval_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  // receiver: picks a new stall style whenever its mode counter runs out
  int stall_mode, mode_left;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_if.ready <= 1'b1;                          // no stalls
        1: out_if.ready <= 1'($urandom_range(0, 1));      // coin flip
        2: out_if.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one radius item; sender may idle between bursts
  task automatic send_radius(input logic [23:0] radius, input logic [7:0] base);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data <= {radius, base};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and let every expected result come back
  task automatic drain(input int extra);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // all four registers, written back to back while idle
  task automatic load_regs(input logic [23:0] cutoff, input logic [23:0] inv_cut,
                           input logic [23:0] amp, input logic [6:0] count);
    logic [23:0] vals[4];
    vals = '{cutoff, inv_cut, amp, 24'(count)};
    drain(DrainCycles);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cutoff = cutoff;
  endtask

  function automatic logic [23:0] pick_radius();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'd0;
    if (sel == 1) return cur_cutoff;
    if (sel <= 3) return 24'($urandom());               // often beyond the cutoff
    return (cur_cutoff == 0) ? 24'd0 : 24'($urandom_range(1, cur_cutoff));
  endfunction

  initial begin
    logic [23:0] cut, inv;
    logic [6:0] cnt;
    int n_items;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    sent = 0;
    burst_left = 4;
    cur_cutoff = 24'd327680;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: zero radius, exactly at and just past the cutoff, extremes
    send_radius(24'd0, 8'd0);
    send_radius(24'd1, 8'd255);
    send_radius(24'd327680, 8'd17);
    send_radius(24'd327681, 8'd200);
    send_radius(24'hFFFFFF, 8'd255);
    send_radius(24'd163840, 8'd1);
    send_radius(24'd81920, 8'd128);

    // zero cutoff: zero radius still takes the zero radius rule
    load_regs(24'd0, 24'hFFFFFF, 24'hFFFFFF, 7'd3);
    send_radius(24'd0, 8'd250);
    send_radius(24'd1, 8'd3);

    // full count, largest registers so both sine sign and saturation show up
    load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd64);
    send_radius(24'd0, 8'd255);
    send_radius(24'd1, 8'd0);
    send_radius(24'hFFFFFF, 8'd192);
    send_radius(24'h800000, 8'd77);

    // count above the maximum is clamped to the maximum
    load_regs(24'd65536, 24'd65536, 24'd1048576, 7'd127);
    send_radius(24'd32768, 8'd255);
    send_radius(24'd65536, 8'd9);

    // zero count: radii accepted, nothing comes back
    load_regs(24'd655360, 24'd6553, 24'd0, 7'd0);
    send_radius(24'd0, 8'd5);
    send_radius(24'd1000, 8'd6);
    send_radius(24'hFFFFFF, 8'd7);

    // minimum cutoff, zero amplitude
    load_regs(24'd1, 24'd0, 24'd0, 7'd2);
    send_radius(24'd1, 8'd255);
    send_radius(24'd2, 8'd0);

    // random phases
    while (sent < RandomItems) begin
      cut = ($urandom_range(0, 7) == 0) ? 24'($urandom()) :
            24'($urandom_range(1 << 14, 16 << 16));
      if (cut == 0) cut = 24'd1;
      inv = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
            (((64'd1 << 32) / cut) > 64'hFFFFFF ? 24'hFFFFFF : 24'((64'd1 << 32) / cut));
      case ($urandom_range(0, 11))
        0: cnt = 7'd0;
        1: cnt = 7'd64;
        2: cnt = 7'($urandom_range(65, 127));
        3: cnt = 7'($urandom_range(9, 20));
        default: cnt = 7'($urandom_range(1, 8));
      endcase
      load_regs(cut, inv, 24'($urandom_range(0, 1 << 22)) | ($urandom_range(0, 9) == 0 ?
                24'hC00000 : 24'h0), cnt);
      n_items = (cnt > 20) ? 4 : 40;
      for (int i = 0; i < n_items; i++) begin
        // hold off once per phase until the block is empty
        if (i == n_items / 2) drain(0);
        send_radius(pick_radius(), 8'($urandom()));
      end
    end

    drain(DrainCycles);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ spherical_bessel_basis_eval.f @@
+incdir+hw/rtl
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_stream_if.sv
hw/rtl/sbb_front.sv
hw/rtl/sbb_back.sv
hw/rtl/spherical_bessel_basis_eval.sv
dv/spherical_bessel_basis_eval_checker.sv
dv/spherical_bessel_basis_eval_tb.sv
